// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; included by the checker by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low
`define GEA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define GEA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/gea_pkg.sv -----
// Package for the GEMM epilogue: beat types, register codes, fp32 helpers.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package gea_pkg;

  typedef struct packed {
    logic [31:0] raw_value;
    logic [31:0] c_value;
    logic        last_in;
  } gea_in_t;

  typedef struct packed {
    logic [31:0] d_value;
    logic        last_out;
  } gea_out_t;

  typedef enum logic [2:0] {
    REG_ALPHA   = 3'd0,
    REG_BETA    = 3'd1,
    REG_USE_C   = 3'd2,
    REG_RAW_FMT = 3'd3,
    REG_C_FMT   = 3'd4,
    REG_OUT_FMT = 3'd5
  } reg_idx_t;

  localparam logic [31:0] ALPHA_RESET = 32'h3F80_0000;
  localparam logic [31:0] FP32_QNAN   = 32'h7FC0_0000;
  localparam logic [15:0] BF16_QNAN   = 16'h7FC0;
  localparam logic [14:0] BF16_MAXMAG = 15'h7F7F;
  localparam logic [30:0] FP32_INFMAG = 31'h7F80_0000;

  localparam int MUL_LAT  = 3;
  localparam int ADD_LAT  = 4;
  localparam int PIPE_LAT = MUL_LAT + ADD_LAT + 1;

  // Count leading zeros of a 48-bit word; 48 for zero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] c;
    logic       f;
    c = 6'd48;
    f = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!f && v[i]) begin
        c = 6'(47 - i);
        f = 1'b1;
      end
    end
    return c;
  endfunction

  // Round to nearest even and pack; n has its leading one at bit 47 or is zero
  function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] er,
                                             input logic [47:0] n);
    logic [47:0] sh_n;
    logic [10:0] rsh;
    logic [7:0]  ee;
    logic [23:0] m;
    logic        lost;
    logic        g;
    logic        st;
    logic        up;
    logic [30:0] mag;
    if (n == 48'd0) return {s, 31'd0};
    if (er >= 11'sd255) return {s, FP32_INFMAG};
    if (er <= 11'sd0) begin
      rsh  = 11'(11'sd1 - er);
      sh_n = n >> rsh;
      lost = |(n & ~({48{1'b1}} << rsh));
      ee   = 8'd0;
    end else begin
      sh_n = n;
      lost = 1'b0;
      ee   = er[7:0];
    end
    m   = sh_n[47:24];
    g   = sh_n[23];
    st  = (|sh_n[22:0]) | lost;
    up  = g & (st | m[0]);
    mag = {ee, m[22:0]} + 31'(up);
    return {s, mag};
  endfunction

  // fp32 to bf16 with round to nearest even, saturating at the largest finite value
  function automatic logic [15:0] to_bf16_sat(input logic [31:0] b);
    logic [30:0] mag;
    logic [31:0] sum;
    logic [15:0] r;
    mag = b[30:0];
    sum = {1'b0, mag} + 32'h0000_7FFF + 32'(mag[16]);
    r   = sum[31:16];
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) return BF16_QNAN;
    if (mag == FP32_INFMAG) return {b[31], BF16_MAXMAG};
    if (r >= 16'h7F80) return {b[31], BF16_MAXMAG};
    return {b[31], r[14:0]};
  endfunction

endpackage
`default_nettype wire

// ----- src/gea_fmul.sv -----
// Three-stage fp32 multiplier with round to nearest even and subnormals.
// Depends on gea_pkg (lzc48, round_pack, constants).
`timescale 1ns / 1ps
`default_nettype none
module gea_fmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_tag,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic        out_tag,
  output logic [31:0] y
);
  import gea_pkg::*;

  // Unpack operands and flag special values
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [23:0] ma, mb;
  logic [9:0]  eea, eeb;
  assign a_nan  = (&a[30:23]) && (|a[22:0]);
  assign a_inf  = (&a[30:23]) && !(|a[22:0]);
  assign a_zero = !(|a[30:0]);
  assign b_nan  = (&b[30:23]) && (|b[22:0]);
  assign b_inf  = (&b[30:23]) && !(|b[22:0]);
  assign b_zero = !(|b[30:0]);
  assign ma  = {|a[30:23], a[22:0]};
  assign mb  = {|b[30:23], b[22:0]};
  assign eea = (|a[30:23]) ? {2'b00, a[30:23]} : 10'd1;
  assign eeb = (|b[30:23]) ? {2'b00, b[30:23]} : 10'd1;

  // Stage 1: multiply mantissas, sum exponents
  logic        v1_r, t1_r, s1_r, nan1_r, inf1_r;
  logic [47:0] p1_r;
  logic [9:0]  es1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    t1_r   <= in_tag;
    s1_r   <= a[31] ^ b[31];
    nan1_r <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    inf1_r <= a_inf | b_inf;
    p1_r   <= ma * mb;
    es1_r  <= eea + eeb;
  end

  // Stage 2: normalize the product so its leading one sits at bit 47
  logic [5:0]         lz2;
  logic signed [10:0] er2_nxt;
  assign lz2     = lzc48(p1_r);
  assign er2_nxt = 11'({1'b0, es1_r}) - 11'd126 - 11'(lz2);

  logic               v2_r, t2_r, s2_r, nan2_r, inf2_r;
  logic [47:0]        n2_r;
  logic signed [10:0] er2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    t2_r   <= t1_r;
    s2_r   <= s1_r;
    nan2_r <= nan1_r;
    inf2_r <= inf1_r;
    n2_r   <= p1_r << lz2;
    er2_r  <= er2_nxt;
  end

  // Stage 3: round and pack, override for special values
  logic [31:0] y_nxt;
  always_comb begin
    priority if (nan2_r) begin
      y_nxt = FP32_QNAN;
    end else if (inf2_r) begin
      y_nxt = {s2_r, FP32_INFMAG};
    end else begin
      y_nxt = round_pack(s2_r, er2_r, n2_r);
    end
  end

  logic        v3_r, t3_r;
  logic [31:0] y3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    t3_r <= t2_r;
    y3_r <= y_nxt;
  end

  assign out_valid = v3_r;
  assign out_tag   = t3_r;
  assign y         = y3_r;

endmodule
`default_nettype wire

// ----- src/gea_fadd.sv -----
// Four-stage fp32 adder with round to nearest even and subnormals.
// Depends on gea_pkg (lzc48, round_pack, constants).
`timescale 1ns / 1ps
`default_nettype none
module gea_fadd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_tag,
  input  logic [31:0] x,
  input  logic [31:0] z,
  output logic        out_valid,
  output logic        out_tag,
  output logic [31:0] y
);
  import gea_pkg::*;

  // Classify operands and order them by magnitude
  logic        x_nan, x_inf, z_nan, z_inf, x_big;
  logic [31:0] big, sml;
  logic [7:0]  eb, es;
  assign x_nan = (&x[30:23]) && (|x[22:0]);
  assign x_inf = (&x[30:23]) && !(|x[22:0]);
  assign z_nan = (&z[30:23]) && (|z[22:0]);
  assign z_inf = (&z[30:23]) && !(|z[22:0]);
  assign x_big = x[30:0] >= z[30:0];
  assign big   = x_big ? x : z;
  assign sml   = x_big ? z : x;
  assign eb    = (|big[30:23]) ? big[30:23] : 8'd1;
  assign es    = (|sml[30:23]) ? sml[30:23] : 8'd1;

  // Stage 1: hold sorted operands and special flags
  logic        v1_r, t1_r, sb1_r, sub1_r, zs1_r, nan1_r, inf1_r, infs1_r;
  logic [7:0]  eb1_r, d1_r;
  logic [23:0] mb1_r, ms1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    t1_r    <= in_tag;
    sb1_r   <= big[31];
    sub1_r  <= x[31] ^ z[31];
    zs1_r   <= x[31] & z[31];
    nan1_r  <= x_nan | z_nan | (x_inf & z_inf & (x[31] ^ z[31]));
    inf1_r  <= x_inf | z_inf;
    infs1_r <= x_inf ? x[31] : z[31];
    eb1_r   <= eb;
    d1_r    <= eb - es;
    mb1_r   <= {|big[30:23], big[22:0]};
    ms1_r   <= {|sml[30:23], sml[22:0]};
  end

  // Stage 2: align the smaller operand with guard, round and sticky bits, then add or subtract
  logic [4:0]  dc;
  logic [53:0] al;
  logic [26:0] sm27;
  logic [27:0] r2_nxt;
  assign dc   = (d1_r > 8'd27) ? 5'd27 : d1_r[4:0];
  assign al   = {ms1_r, 30'd0} >> dc;
  assign sm27 = {al[53:28], al[27] | (|al[26:0])};
  assign r2_nxt = sub1_r ? ({1'b0, mb1_r, 3'b000} - {1'b0, sm27})
                         : ({1'b0, mb1_r, 3'b000} + {1'b0, sm27});

  logic        v2_r, t2_r, sb2_r, zs2_r, nan2_r, inf2_r, infs2_r;
  logic [7:0]  eb2_r;
  logic [27:0] r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    t2_r    <= t1_r;
    sb2_r   <= sb1_r;
    zs2_r   <= zs1_r;
    nan2_r  <= nan1_r;
    inf2_r  <= inf1_r;
    infs2_r <= infs1_r;
    eb2_r   <= eb1_r;
    r2_r    <= r2_nxt;
  end

  // Stage 3: normalize; an exact zero is negative only when both operands are negative
  logic [47:0]        n3w;
  logic [5:0]         lz3;
  logic signed [10:0] er3_nxt;
  assign n3w     = {r2_r, 20'd0};
  assign lz3     = lzc48(n3w);
  assign er3_nxt = 11'({3'b000, eb2_r}) + 11'sd1 - 11'(lz3);

  logic               v3_r, t3_r, s3_r, nan3_r, inf3_r, infs3_r;
  logic [47:0]        n3_r;
  logic signed [10:0] er3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    t3_r    <= t2_r;
    s3_r    <= (r2_r == 28'd0) ? zs2_r : sb2_r;
    nan3_r  <= nan2_r;
    inf3_r  <= inf2_r;
    infs3_r <= infs2_r;
    n3_r    <= n3w << lz3;
    er3_r   <= er3_nxt;
  end

  // Stage 4: round and pack, override for special values
  logic [31:0] y_nxt;
  always_comb begin
    priority if (nan3_r) begin
      y_nxt = FP32_QNAN;
    end else if (inf3_r) begin
      y_nxt = {infs3_r, FP32_INFMAG};
    end else begin
      y_nxt = round_pack(s3_r, er3_r, n3_r);
    end
  end

  logic        v4_r, t4_r;
  logic [31:0] y4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    t4_r <= t3_r;
    y4_r <= y_nxt;
  end

  assign out_valid = v4_r;
  assign out_tag   = t4_r;
  assign y         = y4_r;

endmodule
`default_nettype wire

// ----- src/gemm_epilogue_alpha_beta_core.sv -----
// Top level of the GEMM epilogue d = alpha*raw + beta*c: registers, datapath, output format.
// Depends on gea_pkg, gea_fmul and gea_fadd.
//
// One element enters per clock: busy never rises, so start may be held high every cycle.
// Each element's result appears on out_data, marked by a one-cycle out_valid, in input
// order; the receiver has no way to stall it. On its way it passes through the three
// multiplier stages (both products in parallel), the four adder stages and the output
// format register. Registers are written over the APB-style port and must only
// change while no element is in flight.
`timescale 1ns / 1ps
`default_nettype none
module gemm_epilogue_alpha_beta_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gea_pkg::gea_in_t  in_data,
  output logic              out_valid,
  output gea_pkg::gea_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import gea_pkg::*;

  // Configuration registers
  logic [31:0] alpha_r, beta_r;
  logic        use_c_r, raw_bf_r, c_bf_r, out_bf_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_RESET;
      beta_r   <= 32'd0;
      use_c_r  <= 1'b0;
      raw_bf_r <= 1'b0;
      c_bf_r   <= 1'b0;
      out_bf_r <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ALPHA:   alpha_r  <= pwdata;
        REG_BETA:    beta_r   <= pwdata;
        REG_USE_C:   use_c_r  <= pwdata[0];
        REG_RAW_FMT: raw_bf_r <= pwdata[0];
        REG_C_FMT:   c_bf_r   <= pwdata[0];
        REG_OUT_FMT: out_bf_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_ALPHA:   prdata = alpha_r;
      REG_BETA:    prdata = beta_r;
      REG_USE_C:   prdata = {31'd0, use_c_r};
      REG_RAW_FMT: prdata = {31'd0, raw_bf_r};
      REG_C_FMT:   prdata = {31'd0, c_bf_r};
      REG_OUT_FMT: prdata = {31'd0, out_bf_r};
      default:     prdata = 32'd0;
    endcase
  end

  // Accept a beat every cycle; widen inputs to fp32
  logic        acc;
  logic [31:0] raw_w, c_w;
  assign busy  = 1'b0;
  assign acc   = start & ~busy;
  assign raw_w = raw_bf_r ? {in_data.raw_value[15:0], 16'd0} : in_data.raw_value;
  assign c_w   = !use_c_r ? 32'd0
               : (c_bf_r ? {in_data.c_value[15:0], 16'd0} : in_data.c_value);

  // Both products run in lockstep
  logic        pa_v, pa_t, pb_v, pb_t;
  logic [31:0] pa, pb;

  gea_fmul u_mul_alpha (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_tag(in_data.last_in),
    .a(alpha_r), .b(raw_w), .out_valid(pa_v), .out_tag(pa_t), .y(pa)
  );

  gea_fmul u_mul_beta (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_tag(in_data.last_in),
    .a(beta_r), .b(c_w), .out_valid(pb_v), .out_tag(pb_t), .y(pb)
  );

  logic        s_v, s_t;
  logic [31:0] s_y;

  gea_fadd u_add (
    .clk(clk), .rst_n(rst_n), .in_valid(pa_v & pb_v), .in_tag(pa_t & pb_t),
    .x(pa), .z(pb), .out_valid(s_v), .out_tag(s_t), .y(s_y)
  );

  // Output format: canonical NaN for fp32, saturating bf16 otherwise
  logic [31:0] d_nxt;
  always_comb begin
    if (out_bf_r) begin
      d_nxt = {16'd0, to_bf16_sat(s_y)};
    end else if ((&s_y[30:23]) && (|s_y[22:0])) begin
      d_nxt = FP32_QNAN;
    end else begin
      d_nxt = s_y;
    end
  end

  logic        ov_r;
  gea_out_t    od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= s_v;
    end
    od_r.d_value  <= d_nxt;
    od_r.last_out <= s_t;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
`default_nettype wire

// ----- src/gea_checker.sv -----
// Port-level checker for the GEMM epilogue top level, attached by bind.
// Depends on gea_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gea_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input gea_pkg::gea_out_t out_data
);
  import gea_pkg::*;

  // Accepted input beat and NaN on the result port
  logic acc_w, out_nan;
  assign acc_w   = start && !busy;
  assign out_nan = out_valid && (&out_data.d_value[30:23]) && (|out_data.d_value[22:0]);

  // The pipeline never pushes back
  `GEA_ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy asserted")

  // Every accepted beat yields a result on out_valid
  `GEA_ASSERT_RST(a_result_follows, clk, rst_n, acc_w |-> ##PIPE_LAT out_valid, "result lost")

  // No result without an accepted beat at the matching cycle
  `GEA_ASSERT_RST(a_no_spurious, clk, rst_n, out_valid |-> $past(acc_w, PIPE_LAT), "spurious")

  // Any NaN leaving the block is the canonical quiet NaN
  `GEA_ASSERT_RST(a_nan_canon, clk, rst_n, out_nan |-> (out_data.d_value == FP32_QNAN), "bad NaN")

endmodule

bind gemm_epilogue_alpha_beta_core gea_checker u_gea_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
`default_nettype wire
